[src/mcsc_pkg.sv]
package mcsc_pkg;

  localparam int unsigned RUN_W  = 15;
  localparam int unsigned RES_W  = 20;
  localparam int unsigned PROD_W = RUN_W + RES_W;
  localparam int unsigned REM_W  = 62;
  localparam int unsigned DIV_W  = 59;
  localparam int unsigned QUO_W  = 10;
  localparam int unsigned NCELL  = QUO_W;
  localparam int unsigned GS_W   = 8;
  localparam int unsigned SC_W   = 5;
  localparam int unsigned SV_W   = 9;
  localparam int unsigned WORD_W = 20;

  // sqrt2 / 0.325 V at 24 fractional bits
  localparam logic [26:0] SQ2_VREF_Q24 = 27'd73004820;
  localparam logic [DIV_W-1:0] GS_DIV  = DIV_W'(64'd65536000000000);
  localparam logic [REM_W-1:0] GS_HALF = REM_W'(64'd32768000000000);
  localparam logic [DIV_W-1:0] CS_UNIT = DIV_W'(64'd2048000000000);
  localparam logic [SV_W-1:0]  GS_MIN  = SV_W'(32);
  localparam logic [SV_W-1:0]  GS_FULL = SV_W'(256);
  localparam logic [QUO_W-1:0] SC_SAT  = QUO_W'(33);
  localparam logic [SC_W-1:0]  SC_MAX  = SC_W'(31);
  localparam logic [3:0]       HOLD_DELAY = 4'd6;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dv;
    logic [QUO_W-1:0] quo;
  } lane_t;

endpackage

[src/mcsc_if.sv]
interface mcsc_req_if;
  logic        valid;
  logic        ready;
  logic [14:0] run_current_ma;
  logic [14:0] hold_current_ma;
  logic [19:0] sense_micro_ohm;
  modport source (output valid, run_current_ma, hold_current_ma, sense_micro_ohm,
                  input ready);
  modport sink   (input valid, run_current_ma, hold_current_ma, sense_micro_ohm,
                  output ready);
endinterface

interface mcsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  global_scaler;
  logic [4:0]  run_scale;
  logic [4:0]  hold_scale;
  logic [19:0] hold_run_word;
  modport source (output valid, global_scaler, run_scale, hold_scale, hold_run_word,
                  input ready);
  modport sink   (input valid, global_scaler, run_scale, hold_scale, hold_run_word,
                  output ready);
endinterface

[src/mcsc_div_cell.sv]
module mcsc_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  mcsc_pkg::lane_t lane_i,
  output mcsc_pkg::lane_t lane_o
);
  import mcsc_pkg::*;

  localparam int unsigned CMP_W = DIV_W + QUO_W;

  logic [CMP_W-1:0] trial;
  logic [CMP_W-1:0] rem_x;
  logic             ge;
  lane_t            lane_d, lane_q;

  always_comb begin
    trial  = CMP_W'(lane_i.dv) << SHIFT;
    rem_x  = CMP_W'(lane_i.rem);
    ge     = rem_x >= trial;
    lane_d = lane_i;
    if (ge) begin
      lane_d.rem = REM_W'(rem_x - trial);
      lane_d.quo = lane_i.quo | (QUO_W'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[src/motor_current_scale_calculator_unit.sv]
// Current scale calculator: takes run/hold current (mA) and sense resistance (uOhm), returns
// the global scaler, run and hold scale codes and the packed hold/run word. Accepts one request
// per cycle while the pipeline is not stalled; each result passes through two multiply stages, a 10-cell
// restoring divider chain for the global scaler, a scaler stage, two parallel 10-cell divider
// chains for the scale codes, and the output register. Whole pipeline stalls while a result
// waits at the output.
module motor_current_scale_calculator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcsc_req_if.sink    req_i,
  mcsc_rsp_if.source  rsp_o
);
  import mcsc_pkg::*;

  logic en;
  assign en = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  // stage 1: current times resistance
  logic              v1_q;
  logic [PROD_W-1:0] p_run_q, p_hold_q;
  logic [RUN_W-1:0]  hold_lim;
  assign hold_lim = (req_i.hold_current_ma > req_i.run_current_ma) ?
                    req_i.run_current_ma : req_i.hold_current_ma;

  // stage 2: apply constant
  logic             v2_q;
  logic [REM_W-1:0] n_run_q, n_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_run_q  <= PROD_W'(req_i.run_current_ma) * PROD_W'(req_i.sense_micro_ohm);
      p_hold_q <= PROD_W'(hold_lim) * PROD_W'(req_i.sense_micro_ohm);
      n_run_q  <= REM_W'(p_run_q) * REM_W'(SQ2_VREF_Q24);
      n_hold_q <= REM_W'(p_hold_q) * REM_W'(SQ2_VREF_Q24);
    end
  end

  // global scaler divider chain
  lane_t            gl [NCELL+1];
  logic             gv_q  [NCELL];
  logic [REM_W-1:0] gnr_q [NCELL];
  logic [REM_W-1:0] gnh_q [NCELL];

  assign gl[0] = '{rem: n_run_q + GS_HALF, dv: GS_DIV, quo: '0};

  for (genvar k = 0; k < NCELL; k++) begin : g_gs
    mcsc_div_cell #(.SHIFT(NCELL - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (gl[k]),
      .lane_o (gl[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        gv_q[k] <= 1'b0;
      end else if (en) begin
        gv_q[k] <= (k == 0) ? v2_q : gv_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        gnr_q[k] <= (k == 0) ? n_run_q  : gnr_q[(k == 0) ? 0 : k-1];
        gnh_q[k] <= (k == 0) ? n_hold_q : gnh_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // stage 3: effective scaler and scale divisor
  logic [QUO_W-1:0] gq;
  logic [GS_W-1:0]  gs_d;
  logic [SV_W-1:0]  sv;
  logic             v3_q;
  logic [GS_W-1:0]  gs3_q;
  logic [DIV_W-1:0] e_q;
  logic [REM_W-1:0] nr3_q, nh3_q;

  always_comb begin
    gq = gl[NCELL].quo;
    if (gq[9] || gq[8]) begin
      gs_d = '0;
      sv   = GS_FULL;
    end else if (gq[7:0] < GS_MIN[7:0]) begin
      gs_d = GS_MIN[7:0];
      sv   = GS_MIN;
    end else begin
      gs_d = gq[7:0];
      sv   = SV_W'(gq[7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= gv_q[NCELL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gs3_q <= gs_d;
      e_q   <= DIV_W'(sv) * CS_UNIT;
      nr3_q <= gnr_q[NCELL-1];
      nh3_q <= gnh_q[NCELL-1];
    end
  end

  // scale code divider chains, run and hold side by side
  lane_t           rl [NCELL+1];
  lane_t           hl [NCELL+1];
  logic            sv_q  [NCELL];
  logic [GS_W-1:0] sgs_q [NCELL];

  assign rl[0] = '{rem: nr3_q + REM_W'(e_q >> 1), dv: e_q, quo: '0};
  assign hl[0] = '{rem: nh3_q + REM_W'(e_q >> 1), dv: e_q, quo: '0};

  for (genvar k = 0; k < NCELL; k++) begin : g_sc
    mcsc_div_cell #(.SHIFT(NCELL - 1 - k)) u_run (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (rl[k]),
      .lane_o (rl[k+1])
    );
    mcsc_div_cell #(.SHIFT(NCELL - 1 - k)) u_hold (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (hl[k]),
      .lane_o (hl[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en) begin
        sv_q[k] <= (k == 0) ? v3_q : sv_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sgs_q[k] <= (k == 0) ? gs3_q : sgs_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // output register
  function automatic logic [SC_W-1:0] to_code(input logic [QUO_W-1:0] q);
    logic [SC_W-1:0] c;
    if (q == '0) begin
      c = '0;
    end else if (q >= SC_SAT) begin
      c = SC_MAX;
    end else begin
      c = SC_W'(q - QUO_W'(1));
    end
    return c;
  endfunction

  logic            out_v_q;
  logic [GS_W-1:0] gs_q;
  logic [SC_W-1:0] rs_q, hs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sv_q[NCELL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gs_q <= sgs_q[NCELL-1];
      rs_q <= to_code(rl[NCELL].quo);
      hs_q <= to_code(hl[NCELL].quo);
    end
  end

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.global_scaler = gs_q;
  assign rsp_o.run_scale     = rs_q;
  assign rsp_o.hold_scale    = hs_q;
  assign rsp_o.hold_run_word = {HOLD_DELAY, 3'b000, rs_q, 3'b000, hs_q};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("request stalled with empty output");

  a_gs_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.global_scaler == '0 || rsp_o.global_scaler >= GS_MIN[7:0]))
    else $error("global scaler below floor");

  a_hold_le_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.hold_scale <= rsp_o.run_scale)
    else $error("hold scale above run scale");

endmodule
